// ----- rtl/msb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_pkg
// Shared types, constants and the character pattern table for the Morse
// symbol blinker.
// ----------------------------------------------------------------------------
package msb_pkg;

  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned TICKS_W = 18;
  localparam int unsigned CODE_W  = 6;

  localparam logic [CODE_W-1:0] CODE_COUNT = 6'd36;

  // request kinds carried in tuser
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic [4:0]         pattern_bits;
    logic [2:0]         element_total;
    logic [2:0]         element_position;
    logic               in_gap;
    logic [TICKS_W-1:0] ticks_left;
    logic               sending;
  } keyer_state_t;

  // packed as in tdata: led_on in the lowest bit
  typedef struct packed {
    logic done_res;
    logic accepted;
    logic busy_res;
    logic led_on;
  } keyer_result_t;

  // {element count, dah mask}, bit i of the mask is element i
  function automatic logic [7:0] code_entry(input logic [CODE_W-1:0] code);
    logic [7:0] e;
    unique case (code)
      6'd0:  e = {3'd2, 5'd2};
      6'd1:  e = {3'd4, 5'd1};
      6'd2:  e = {3'd4, 5'd5};
      6'd3:  e = {3'd3, 5'd1};
      6'd4:  e = {3'd1, 5'd0};
      6'd5:  e = {3'd4, 5'd4};
      6'd6:  e = {3'd3, 5'd3};
      6'd7:  e = {3'd4, 5'd0};
      6'd8:  e = {3'd2, 5'd0};
      6'd9:  e = {3'd4, 5'd14};
      6'd10: e = {3'd3, 5'd5};
      6'd11: e = {3'd4, 5'd2};
      6'd12: e = {3'd2, 5'd3};
      6'd13: e = {3'd2, 5'd1};
      6'd14: e = {3'd3, 5'd7};
      6'd15: e = {3'd4, 5'd6};
      6'd16: e = {3'd4, 5'd11};
      6'd17: e = {3'd3, 5'd2};
      6'd18: e = {3'd3, 5'd0};
      6'd19: e = {3'd1, 5'd1};
      6'd20: e = {3'd3, 5'd4};
      6'd21: e = {3'd4, 5'd8};
      6'd22: e = {3'd3, 5'd6};
      6'd23: e = {3'd4, 5'd9};
      6'd24: e = {3'd4, 5'd13};
      6'd25: e = {3'd4, 5'd3};
      6'd26: e = {3'd5, 5'd31};
      6'd27: e = {3'd5, 5'd30};
      6'd28: e = {3'd5, 5'd28};
      6'd29: e = {3'd5, 5'd24};
      6'd30: e = {3'd5, 5'd16};
      6'd31: e = {3'd5, 5'd0};
      6'd32: e = {3'd5, 5'd1};
      6'd33: e = {3'd5, 5'd3};
      6'd34: e = {3'd5, 5'd7};
      6'd35: e = {3'd5, 5'd15};
      default: e = 8'd0;
    endcase
    return e;
  endfunction

endpackage

// ----- rtl/msb_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_step
// Next-state and result logic for one load or tick word of the keyer.
// ----------------------------------------------------------------------------
module msb_step (
  input  msb_pkg::keyer_state_t              state,
  input  logic [msb_pkg::UNIT_W-1:0]         unit_ticks,
  input  logic                               req_type,
  input  logic [msb_pkg::CODE_W-1:0]         char_code,
  output msb_pkg::keyer_state_t              state_next,
  output msb_pkg::keyer_result_t             result
);

  logic [msb_pkg::TICKS_W-1:0] unit_len;
  logic [msb_pkg::TICKS_W-1:0] dah_len;
  logic [7:0]                  entry;
  logic [7:0]                  load_pattern;
  logic [7:0]                  cur_pattern;
  logic [2:0]                  pos_inc;
  logic [2:0]                  last_pos;
  logic [msb_pkg::TICKS_W-1:0] ticks_dec;

  always_comb begin
    unit_len = (unit_ticks == '0) ? msb_pkg::TICKS_W'(1)
                                  : msb_pkg::TICKS_W'(unit_ticks);
    dah_len  = unit_len + {unit_len[msb_pkg::TICKS_W-2:0], 1'b0};
  end

  always_comb begin
    entry        = msb_pkg::code_entry(char_code);
    load_pattern = {3'b000, entry[4:0]};
    cur_pattern  = {3'b000, state.pattern_bits};
    pos_inc      = state.element_position + 3'd1;
    last_pos     = state.element_total - 3'd1;
    ticks_dec    = (state.ticks_left != '0) ? state.ticks_left - msb_pkg::TICKS_W'(1)
                                            : state.ticks_left;
  end

  always_comb begin
    state_next = state;
    result     = '0;
    if (req_type == msb_pkg::REQ_LOAD) begin
      if (!state.sending && char_code < msb_pkg::CODE_COUNT) begin
        state_next.pattern_bits     = entry[4:0];
        state_next.element_total    = entry[7:5];
        state_next.element_position = 3'd0;
        state_next.in_gap           = 1'b0;
        state_next.ticks_left       = load_pattern[0] ? dah_len : unit_len;
        state_next.sending          = 1'b1;
        result.accepted             = 1'b1;
      end
    end else if (state.sending) begin
      result.led_on         = !state.in_gap;
      state_next.ticks_left = ticks_dec;
      if (ticks_dec == '0) begin
        priority if (state.in_gap) begin
          state_next.in_gap           = 1'b0;
          state_next.element_position = pos_inc;
          state_next.ticks_left       = cur_pattern[pos_inc] ? dah_len : unit_len;
        end else if (state.element_position >= last_pos
                     || state.element_total == 3'd0) begin
          state_next.sending = 1'b0;
          result.done_res    = 1'b1;
        end else begin
          state_next.in_gap     = 1'b1;
          state_next.ticks_left = unit_len;
        end
      end
    end
    result.busy_res = state_next.sending;
  end

endmodule

// ----- rtl/morse_symbol_blinker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_symbol_blinker
// Keys letters and digits as Morse patterns onto an LED level, one tick word
// at a time.
// ----------------------------------------------------------------------------
// Each input word is a load (tuser 0, tdata holds the character code, A-Z as
// 0-25 and 0-9 as 26-35) or a tick (tuser 1). Every word yields exactly one
// result word in the cycle after it is taken; a word can be taken every cycle as
// long as the result register is free or being drained in the same cycle.
// A dit is lit for unit_ticks ticks, a dah for three times that, with a dark
// unit between elements; a unit of zero counts as one. Each mark or gap
// samples unit_ticks when it starts.
module morse_symbol_blinker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,     // unit_ticks
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,       // [5:0] char_code, [7:6] zero
  input  logic        s_tuser,       // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata        // [0] led_on, [1] busy_res, [2] accepted,
                                     // [3] done_res, [7:4] zero
);

  logic [msb_pkg::UNIT_W-1:0] unit_ticks;
  msb_pkg::keyer_state_t      state;
  msb_pkg::keyer_state_t      state_next;
  msb_pkg::keyer_result_t     step_res;
  msb_pkg::keyer_result_t     out_res;
  logic                       s_fire;

  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;

  msb_step u_step (
    .state      (state),
    .unit_ticks (unit_ticks),
    .req_type   (s_tuser),
    .char_code  (s_tdata[msb_pkg::CODE_W-1:0]),
    .state_next (state_next),
    .result     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks <= msb_pkg::UNIT_W'(1);
    end else if (cfg_we) begin
      unit_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_fire) begin
        state    <= state_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      out_res <= step_res;
    end
  end

  assign m_tdata = {4'b0000, out_res};

`ifndef SYNTHESIS
  // an accepted load starts keying
  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    (s_fire && step_res.accepted) |=> state.sending)
    else $error("accepted load did not start keying");

  // the final mark returns the keyer to idle
  a_done_idles: assert property (@(posedge clk) disable iff (rst)
    (s_fire && step_res.done_res) |=> !state.sending)
    else $error("keyer still busy after done");

  // element index stays within the character
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    state.sending |-> (state.element_position < state.element_total))
    else $error("element index past end of character");

  // a running mark or gap always has ticks left
  a_ticks_live: assert property (@(posedge clk) disable iff (rst)
    state.sending |-> (state.ticks_left != '0))
    else $error("keying with an empty tick count");
`endif

endmodule
